>>> design/zip_directory_entry_parser_top_macros.svh
// Assertion macros shared by the ZIP directory entry parser checker.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef ZIP_DIRECTORY_ENTRY_PARSER_TOP_MACROS_SVH
`define ZIP_DIRECTORY_ENTRY_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZDP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ZDP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/zdp_pkg.sv
// Package for the ZIP directory entry parser: result kinds, header layout
// constants, the transaction types and the decode functions. No dependencies.
`default_nettype none

package zdp_pkg;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 5;
	localparam int VALUE_W = 32;
	localparam int LEN_W   = 16;
	localparam int POS_W   = 6;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_MADEBY  = 5'd0;
	localparam logic [KIND_W-1:0] KIND_NEEDED  = 5'd1;
	localparam logic [KIND_W-1:0] KIND_FLAGS   = 5'd2;
	localparam logic [KIND_W-1:0] KIND_METHOD  = 5'd3;
	localparam logic [KIND_W-1:0] KIND_HOUR    = 5'd4;
	localparam logic [KIND_W-1:0] KIND_MINUTE  = 5'd5;
	localparam logic [KIND_W-1:0] KIND_SECOND  = 5'd6;
	localparam logic [KIND_W-1:0] KIND_YEAR    = 5'd7;
	localparam logic [KIND_W-1:0] KIND_MONTH   = 5'd8;
	localparam logic [KIND_W-1:0] KIND_DAY     = 5'd9;
	localparam logic [KIND_W-1:0] KIND_CRC     = 5'd10;
	localparam logic [KIND_W-1:0] KIND_CSIZE   = 5'd11;
	localparam logic [KIND_W-1:0] KIND_USIZE   = 5'd12;
	localparam logic [KIND_W-1:0] KIND_NLEN    = 5'd13;
	localparam logic [KIND_W-1:0] KIND_ELEN    = 5'd14;
	localparam logic [KIND_W-1:0] KIND_CLEN    = 5'd15;
	localparam logic [KIND_W-1:0] KIND_DISK    = 5'd16;
	localparam logic [KIND_W-1:0] KIND_IATTR   = 5'd17;
	localparam logic [KIND_W-1:0] KIND_EATTR   = 5'd18;
	localparam logic [KIND_W-1:0] KIND_OFFSET  = 5'd19;
	localparam logic [KIND_W-1:0] KIND_NAME    = 5'd20;
	localparam logic [KIND_W-1:0] KIND_EXTRA   = 5'd21;
	localparam logic [KIND_W-1:0] KIND_COMMENT = 5'd22;
	localparam logic [KIND_W-1:0] KIND_BADSIG  = 5'd23;
	localparam logic [KIND_W-1:0] KIND_NONE    = 5'd31;

	// Header lengths and date base.
	localparam logic [POS_W-1:0] HDR_LOCAL   = 6'd30;
	localparam logic [POS_W-1:0] HDR_CENTRAL = 6'd46;
	localparam logic [POS_W-1:0] SIG_LEN     = 6'd4;
	localparam logic [10:0]      YEAR_BASE   = 11'd1980;
	localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;
	localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;

	// One result transaction.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               done;
	} result_t;

	// The up to three results caused by one input byte.
	typedef struct packed {
		logic [1:0]        count;
		result_t [2:0]     res;
	} group_t;

	// Expected signature byte: "PK\3\4" for local, "PK\1\2" for central.
	function automatic logic [BYTE_W-1:0] sig_byte(input logic is_local,
		input logic [1:0] idx);
		logic [BYTE_W-1:0] b;
		unique case (idx)
			2'd0: b = 8'h50;
			2'd1: b = 8'h4B;
			2'd2: b = is_local ? 8'h03 : 8'h01;
			default: b = is_local ? 8'h04 : 8'h02;
		endcase
		return b;
	endfunction

	// Kind of the field completed at a header byte index, or none.
	function automatic logic [KIND_W-1:0] field_kind(input logic is_local,
		input logic [POS_W-1:0] pos);
		logic [KIND_W-1:0] k;
		k = KIND_NONE;
		if (is_local) begin
			unique case (pos)
				6'd5:    k = KIND_NEEDED;
				6'd7:    k = KIND_FLAGS;
				6'd9:    k = KIND_METHOD;
				6'd11:   k = KIND_HOUR;
				6'd13:   k = KIND_YEAR;
				6'd17:   k = KIND_CRC;
				6'd21:   k = KIND_CSIZE;
				6'd25:   k = KIND_USIZE;
				6'd27:   k = KIND_NLEN;
				6'd29:   k = KIND_ELEN;
				default: k = KIND_NONE;
			endcase
		end else begin
			unique case (pos)
				6'd5:    k = KIND_MADEBY;
				6'd7:    k = KIND_NEEDED;
				6'd9:    k = KIND_FLAGS;
				6'd11:   k = KIND_METHOD;
				6'd13:   k = KIND_HOUR;
				6'd15:   k = KIND_YEAR;
				6'd19:   k = KIND_CRC;
				6'd23:   k = KIND_CSIZE;
				6'd27:   k = KIND_USIZE;
				6'd29:   k = KIND_NLEN;
				6'd31:   k = KIND_ELEN;
				6'd33:   k = KIND_CLEN;
				6'd35:   k = KIND_DISK;
				6'd37:   k = KIND_IATTR;
				6'd41:   k = KIND_EATTR;
				6'd45:   k = KIND_OFFSET;
				default: k = KIND_NONE;
			endcase
		end
		return k;
	endfunction

endpackage

`default_nettype wire

>>> design/zdp_if.sv
// Valid/ready channel interfaces for the ZIP directory entry parser.
// Depends on zdp_pkg for the field widths.
`default_nettype none

interface zdp_in_if;
	logic                      valid;
	logic                      ready;
	logic [zdp_pkg::BYTE_W-1:0] byte_value;
	logic                      entry_start;
	logic                      local_layout;

	modport source(output valid, byte_value, entry_start, local_layout, input ready);
	modport sink(input valid, byte_value, entry_start, local_layout, output ready);
endinterface

interface zdp_out_if;
	logic                       valid;
	logic                       ready;
	logic [zdp_pkg::KIND_W-1:0]  item_kind;
	logic [zdp_pkg::VALUE_W-1:0] item_value;
	logic                       entry_done;

	modport source(output valid, item_kind, item_value, entry_done, input ready);
	modport sink(input valid, item_kind, item_value, entry_done, output ready);
endinterface

`default_nettype wire

>>> design/zdp_parser.sv
// Entry parser: per-entry state and the decode of one byte into up to three
// results. Depends on zdp_pkg.
`default_nettype none

module zdp_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic [zdp_pkg::BYTE_W-1:0] byte_value,
	input  wire logic                       entry_start,
	input  wire logic                       local_layout,
	output zdp_pkg::group_t                 grp
);

	logic [zdp_pkg::POS_W-1:0]   pos_q, pos_d, pos_cur, hdr;
	logic                        local_q, local_d;
	logic                        skip_q, skip_d, active;
	logic [zdp_pkg::VALUE_W-1:0] acc_q, acc_d, acc_shift;
	logic [zdp_pkg::LEN_W-1:0]   name_q, name_d, extra_q, extra_d, comment_q, comment_d;
	logic [zdp_pkg::LEN_W-1:0]   v16;
	logic [zdp_pkg::KIND_W-1:0]  kind;
	logic                        wide;
	logic [11:0]                 year;

	// Next-state and result decode for the byte at the input.
	always_comb begin
		grp       = '0;
		skip_d    = skip_q;
		local_d   = local_q;
		pos_d     = pos_q;
		acc_d     = acc_q;
		name_d    = name_q;
		extra_d   = extra_q;
		comment_d = comment_q;

		// A start byte abandons any entry in progress.
		if (entry_start) begin
			skip_d    = 1'b0;
			local_d   = local_layout;
			pos_d     = '0;
			name_d    = '0;
			extra_d   = '0;
			comment_d = '0;
		end
		pos_cur   = pos_d;
		active    = entry_start || !skip_q;
		hdr       = local_d ? zdp_pkg::HDR_LOCAL : zdp_pkg::HDR_CENTRAL;
		acc_shift = {byte_value, acc_q[zdp_pkg::VALUE_W-1:zdp_pkg::BYTE_W]};
		v16       = acc_shift[zdp_pkg::VALUE_W-1:zdp_pkg::LEN_W];
		kind      = zdp_pkg::field_kind(local_d, pos_cur);
		wide      = (kind == zdp_pkg::KIND_CRC) || (kind == zdp_pkg::KIND_CSIZE) ||
			(kind == zdp_pkg::KIND_USIZE) || (kind == zdp_pkg::KIND_EATTR) ||
			(kind == zdp_pkg::KIND_OFFSET);
		// The year reaches 2107, so it needs twelve bits.
		year      = {5'd0, v16[15:9]} + {1'b0, zdp_pkg::YEAR_BASE};

		if (active) begin
			if (pos_cur < zdp_pkg::SIG_LEN) begin
				// Signature check, one byte at a time.
				if (byte_value != zdp_pkg::sig_byte(local_d, pos_cur[1:0])) begin
					grp.count        = 2'd1;
					grp.res[0].kind  = zdp_pkg::KIND_BADSIG;
					grp.res[0].value = {24'd0, byte_value};
					grp.res[0].done  = 1'b1;
					skip_d           = 1'b1;
				end else begin
					pos_d = pos_cur + 6'd1;
				end
			end else if (pos_cur < hdr) begin
				// Fixed header fields.
				acc_d = acc_shift;
				pos_d = pos_cur + 6'd1;
				case (kind)
					zdp_pkg::KIND_HOUR: begin
						grp.count        = 2'd3;
						grp.res[0].kind  = zdp_pkg::KIND_HOUR;
						grp.res[0].value = {27'd0, v16[15:11]};
						grp.res[1].kind  = zdp_pkg::KIND_MINUTE;
						grp.res[1].value = {26'd0, v16[10:5]};
						grp.res[2].kind  = zdp_pkg::KIND_SECOND;
						grp.res[2].value = {26'd0, v16[4:0], 1'b0};
					end
					zdp_pkg::KIND_YEAR: begin
						grp.count        = 2'd3;
						grp.res[0].kind  = zdp_pkg::KIND_YEAR;
						grp.res[0].value = {20'd0, year};
						grp.res[1].kind  = zdp_pkg::KIND_MONTH;
						grp.res[1].value = {28'd0, v16[8:5]};
						grp.res[2].kind  = zdp_pkg::KIND_DAY;
						grp.res[2].value = {27'd0, v16[4:0]};
					end
					zdp_pkg::KIND_NONE: begin
						grp.count = 2'd0;
					end
					default: begin
						grp.count        = 2'd1;
						grp.res[0].kind  = kind;
						grp.res[0].value = wide ? acc_shift : {16'd0, v16};
					end
				endcase
				if (kind == zdp_pkg::KIND_NLEN) name_d = v16;
				if (kind == zdp_pkg::KIND_ELEN) extra_d = v16;
				if (kind == zdp_pkg::KIND_CLEN) comment_d = v16;
				// Header end with nothing behind it closes the entry.
				if ((pos_cur + 6'd1 == hdr) && (name_d == '0) && (extra_d == '0) &&
					(comment_d == '0)) begin
					if (grp.count == 2'd3) grp.res[2].done = 1'b1;
					else grp.res[0].done = 1'b1;
					skip_d = 1'b1;
				end
			end else begin
				// Name, extra and comment bytes pass through in that order.
				grp.count        = 2'd1;
				grp.res[0].value = {24'd0, byte_value};
				if (name_q != '0) begin
					grp.res[0].kind = zdp_pkg::KIND_NAME;
					if (byte_value == zdp_pkg::NUL_BYTE)
						grp.res[0].value = {24'd0, zdp_pkg::SPACE_BYTE};
					name_d = name_q - 16'd1;
				end else if (extra_q != '0) begin
					grp.res[0].kind = zdp_pkg::KIND_EXTRA;
					extra_d = extra_q - 16'd1;
				end else if (comment_q != '0) begin
					grp.res[0].kind = zdp_pkg::KIND_COMMENT;
					comment_d = comment_q - 16'd1;
				end else begin
					grp.count = 2'd0;
				end
				if ((name_d == '0) && (extra_d == '0) && (comment_d == '0)) begin
					grp.res[0].done = 1'b1;
					skip_d = 1'b1;
				end
			end
		end
	end

	// Entry state, updated on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			local_q   <= 1'b0;
			skip_q    <= 1'b1;
			acc_q     <= '0;
			name_q    <= '0;
			extra_q   <= '0;
			comment_q <= '0;
		end else if (accept) begin
			pos_q     <= pos_d;
			local_q   <= local_d;
			skip_q    <= skip_d;
			acc_q     <= acc_d;
			name_q    <= name_d;
			extra_q   <= extra_d;
			comment_q <= comment_d;
		end
	end

endmodule

`default_nettype wire

>>> design/zdp_emitter.sv
// Result register: holds the results of one byte and hands them out one
// transaction per ready cycle. Depends on zdp_pkg and zdp_out_if.
`default_nettype none

module zdp_emitter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  zdp_pkg::group_t grp,
	output logic            in_ready,
	zdp_out_if.source       out_ch
);

	logic [1:0]                rem_q;
	zdp_pkg::result_t [2:0]    res_q;
	logic                      pop, load;

	assign pop  = out_ch.valid && out_ch.ready;
	assign load = accept && (grp.count != 2'd0);

	// A new byte may enter when nothing is held or the last held result leaves this cycle.
	assign in_ready = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_ch.ready);

	assign out_ch.valid      = rem_q != 2'd0;
	assign out_ch.item_kind  = res_q[0].kind;
	assign out_ch.item_value = res_q[0].value;
	assign out_ch.entry_done = res_q[0].done;

	// Count of results still held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= grp.count;
		end else if (pop) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// Held results; the head is always in slot zero.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= grp.res;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

`default_nettype wire

>>> design/zip_directory_entry_parser_top.sv
// ZIP directory entry parser, top level.
// Byte input channel in_ch: one entry byte per transaction, entry_start marks
// the first byte and local_layout on it picks local header or central entry.
// Result output channel out_ch: one field, split date/time part or passed
// byte per transaction, with entry_done on the last result of an entry.
// Latency: the results of a byte appear on out_ch the cycle after the byte
// is accepted.
// Throughput: one byte per cycle while each byte gives at most one result
// and out_ch does not stall. A byte that completes the DOS time or date gives
// three results, which the single result register drains one per ready cycle.
// Reset clears all entry state; bytes are ignored until a start byte.
// When out_ch stalls, the held result stays put and in_ch takes a new byte
// only once the last held result is leaving.
// Depends on zdp_pkg, zdp_if, zdp_parser and zdp_emitter.
`default_nettype none

module zip_directory_entry_parser_top (
	input  wire logic clk,
	input  wire logic arst_n,
	zdp_in_if.sink    in_ch,
	zdp_out_if.source out_ch
);

	zdp_pkg::group_t grp;
	logic            in_ready;
	logic            accept;

	assign in_ch.ready = in_ready;
	assign accept      = in_ch.valid && in_ready;

	// Byte decode and entry state.
	zdp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.byte_value   (in_ch.byte_value),
		.entry_start  (in_ch.entry_start),
		.local_layout (in_ch.local_layout),
		.grp          (grp)
	);

	// Result register and serializer.
	zdp_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.grp      (grp),
		.in_ready (in_ready),
		.out_ch   (out_ch)
	);

endmodule

`default_nettype wire

>>> design/zdp_checker.sv
// Port-level checker for the ZIP directory entry parser, with its bind.
// Depends on zdp_pkg and zip_directory_entry_parser_top_macros.svh.
`default_nettype none
`include "zip_directory_entry_parser_top_macros.svh"

module zdp_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [zdp_pkg::KIND_W-1:0]  item_kind,
	input wire logic [zdp_pkg::VALUE_W-1:0] item_value,
	input wire logic                        entry_done
);

	// A stalled result holds until taken.
	`ZDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(item_value) && $stable(item_kind) && $stable(entry_done), "result changed while stalled")

	// A bad signature always closes the entry.
	`ZDP_ASSERT_NOW(a_badsig_done, out_valid && item_kind == zdp_pkg::KIND_BADSIG, entry_done, "bad signature without entry_done")

	// The decoded year lies in the DOS range.
	`ZDP_ASSERT_NOW(a_year_range, out_valid && item_kind == zdp_pkg::KIND_YEAR, item_value >= 32'd1980 && item_value <= 32'd2107, "year out of range")

	// Seconds are doubled and so even and at most 62.
	`ZDP_ASSERT_NOW(a_second_even, out_valid && item_kind == zdp_pkg::KIND_SECOND, !item_value[0] && item_value <= 32'd62, "bad seconds value")

	// Every result carries one of the defined kinds.
	`ZDP_ASSERT_NOW(a_kind_range, out_valid, item_kind <= zdp_pkg::KIND_BADSIG, "result kind out of range")

endmodule

bind zip_directory_entry_parser_top zdp_checker u_zdp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.item_kind  (out_ch.item_kind),
	.item_value (out_ch.item_value),
	.entry_done (out_ch.entry_done)
);

`default_nettype wire

>>> dv/zip_directory_entry_parser_top_tb.sv
// Self-checking testbench for zip_directory_entry_parser_top: it streams local and central
// directory entries, some broken or cut short, and checks every parsed field against a predictor.
// Depends on zdp_pkg, the zdp_in_if and zdp_out_if interfaces, and the parser RTL.
`timescale 1ns / 100ps

module zip_directory_entry_parser_top_tb;

	localparam int RANDOM_ITEMS = 320;
	localparam int HOLD_CYCLES  = 200;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_LIMIT  = 1000;

	typedef enum int {SHAPE_BARE, SHAPE_FULL, SHAPE_CUT, SHAPE_SPOILED} entry_shape_t;

	// Tracks one entry at a time and holds the parsed fields still owed by the block.
	class zip_field_tracker;
		zdp_pkg::result_t fields_due[$];
		int unsigned      hdr_index;
		bit               entry_local;
		logic [31:0]      shift_word;
		logic [15:0]      names_left;
		logic [15:0]      extras_left;
		logic [15:0]      comments_left;
		bit               awaiting_start;
		int               errors;
		int               matched;
		int               bad_sigs;

		function new();
			hdr_index      = 0;
			entry_local    = 1'b0;
			shift_word     = '0;
			names_left     = '0;
			extras_left    = '0;
			comments_left  = '0;
			awaiting_start = 1'b1;
			errors         = 0;
			matched        = 0;
			bad_sigs       = 0;
		endfunction

		function void push_field(logic [zdp_pkg::KIND_W-1:0] kind, logic [31:0] value,
			logic done);
			zdp_pkg::result_t r;
			r.kind  = kind;
			r.value = value;
			r.done  = done;
			fields_due.push_back(r);
		endfunction

		function bit tail_clear();
			return names_left == 0 && extras_left == 0 && comments_left == 0;
		endfunction

		// Fields from version needed to extra length sit two bytes later in a central
		// entry than in a local header, so the central map reuses the local one.
		function logic [zdp_pkg::KIND_W-1:0] local_field_at(int unsigned idx);
			case (idx)
				5:       return zdp_pkg::KIND_NEEDED;
				7:       return zdp_pkg::KIND_FLAGS;
				9:       return zdp_pkg::KIND_METHOD;
				11:      return zdp_pkg::KIND_HOUR;
				13:      return zdp_pkg::KIND_YEAR;
				17:      return zdp_pkg::KIND_CRC;
				21:      return zdp_pkg::KIND_CSIZE;
				25:      return zdp_pkg::KIND_USIZE;
				27:      return zdp_pkg::KIND_NLEN;
				29:      return zdp_pkg::KIND_ELEN;
				default: return zdp_pkg::KIND_NONE;
			endcase
		endfunction

		function logic [zdp_pkg::KIND_W-1:0] field_at(bit loc, int unsigned idx);
			if (loc)
				return local_field_at(idx);
			case (idx)
				5:       return zdp_pkg::KIND_MADEBY;
				33:      return zdp_pkg::KIND_CLEN;
				35:      return zdp_pkg::KIND_DISK;
				37:      return zdp_pkg::KIND_IATTR;
				41:      return zdp_pkg::KIND_EATTR;
				45:      return zdp_pkg::KIND_OFFSET;
				default: return (idx >= 7 && idx <= 31) ? local_field_at(idx - 2) :
					zdp_pkg::KIND_NONE;
			endcase
		endfunction

		function bit full_word(logic [zdp_pkg::KIND_W-1:0] kind);
			return kind == zdp_pkg::KIND_CRC || kind == zdp_pkg::KIND_CSIZE ||
				kind == zdp_pkg::KIND_USIZE || kind == zdp_pkg::KIND_EATTR ||
				kind == zdp_pkg::KIND_OFFSET;
		endfunction

		// Notes one accepted input transaction and queues the fields it should produce.
		function void take_byte(logic [7:0] b, logic start, logic lo);
			int unsigned                hdr_len;
			logic [31:0]                magic;
			logic [zdp_pkg::KIND_W-1:0] kind;
			logic [15:0]                half;
			logic [7:0]                 shown;
			logic                       closing;
			if (start) begin
				awaiting_start = 1'b0;
				entry_local    = lo;
				hdr_index      = 0;
				names_left     = '0;
				extras_left    = '0;
				comments_left  = '0;
			end else if (awaiting_start) begin
				return;
			end

			// Signature bytes, checked one at a time.
			if (hdr_index < 4) begin
				magic = entry_local ? 32'h04034B50 : 32'h02014B50;
				if (b != magic[8*hdr_index +: 8]) begin
					push_field(zdp_pkg::KIND_BADSIG, {24'd0, b}, 1'b1);
					awaiting_start = 1'b1;
					bad_sigs++;
				end else begin
					hdr_index++;
				end
				return;
			end

			// Fixed header: bytes shift in from the top, fields complete on their last byte.
			hdr_len = entry_local ? zdp_pkg::HDR_LOCAL : zdp_pkg::HDR_CENTRAL;
			if (hdr_index < hdr_len) begin
				shift_word = {b, shift_word[31:8]};
				half = shift_word[31:16];
				kind = field_at(entry_local, hdr_index);
				hdr_index++;
				if (kind == zdp_pkg::KIND_NLEN)
					names_left = half;
				if (kind == zdp_pkg::KIND_ELEN)
					extras_left = half;
				if (kind == zdp_pkg::KIND_CLEN)
					comments_left = half;
				closing = (hdr_index == hdr_len) && tail_clear();
				if (kind == zdp_pkg::KIND_HOUR) begin
					push_field(zdp_pkg::KIND_HOUR, {27'd0, half[15:11]}, 1'b0);
					push_field(zdp_pkg::KIND_MINUTE, {26'd0, half[10:5]}, 1'b0);
					push_field(zdp_pkg::KIND_SECOND, {26'd0, half[4:0], 1'b0}, closing);
				end else if (kind == zdp_pkg::KIND_YEAR) begin
					push_field(zdp_pkg::KIND_YEAR,
						{25'd0, half[15:9]} + {21'd0, zdp_pkg::YEAR_BASE}, 1'b0);
					push_field(zdp_pkg::KIND_MONTH, {28'd0, half[8:5]}, 1'b0);
					push_field(zdp_pkg::KIND_DAY, {27'd0, half[4:0]}, closing);
				end else if (kind != zdp_pkg::KIND_NONE) begin
					push_field(kind, full_word(kind) ? shift_word : {16'd0, half}, closing);
				end
				if (closing)
					awaiting_start = 1'b1;
				return;
			end

			// Variable part: name, then extra, then comment bytes.
			if (names_left != 0) begin
				kind  = zdp_pkg::KIND_NAME;
				shown = (b == zdp_pkg::NUL_BYTE) ? zdp_pkg::SPACE_BYTE : b;
				names_left--;
			end else if (extras_left != 0) begin
				kind  = zdp_pkg::KIND_EXTRA;
				shown = b;
				extras_left--;
			end else if (comments_left != 0) begin
				kind  = zdp_pkg::KIND_COMMENT;
				shown = b;
				comments_left--;
			end else begin
				awaiting_start = 1'b1;
				return;
			end
			closing = tail_clear();
			push_field(kind, {24'd0, shown}, closing);
			if (closing)
				awaiting_start = 1'b1;
		endfunction

		task flag_mismatch(string what);
			errors++;
			if (errors <= 30)
				$display("%0t mismatch: %s", $time, what);
		endtask

		// Compares one accepted result transaction with the oldest field owed.
		task match_result(logic [zdp_pkg::KIND_W-1:0] kind, logic [31:0] value, logic done);
			zdp_pkg::result_t want;
			matched++;
			if (fields_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind %0d value %h done %b",
					kind, value, done));
				return;
			end
			want = fields_due.pop_front();
			if (kind !== want.kind)
				flag_mismatch($sformatf("item_kind %0d, want %0d", kind, want.kind));
			if (value !== want.value)
				flag_mismatch($sformatf("item_value %h, want %h (kind %0d)",
					value, want.value, want.kind));
			if (done !== want.done)
				flag_mismatch($sformatf("entry_done %b, want %b (kind %0d)",
					done, want.done, want.kind));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   burst_mode;
	bit   hold_request;
	int   entries_sent;
	int   entry_bytes;
	int   quiet_cycles;
	zip_field_tracker sb;

	zdp_in_if  in_ch();
	zdp_out_if out_ch();

	zip_directory_entry_parser_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Wait before a transaction: none in burst stretches, otherwise often none and sometimes a random one.
	function int draw_wait();
		if (burst_mode || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offers one byte and returns at the edge where the block takes it.
	task automatic send_byte(input logic [7:0] b, input logic start, input logic lo);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.byte_value   <= b;
		in_ch.entry_start  <= start;
		in_ch.local_layout <= lo;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Builds and sends one entry; cut entries carry huge lengths and stop early,
	// spoiled ones get one corrupted signature byte.
	task automatic send_entry(input bit loc, input int flavor, input entry_shape_t shape);
		logic [7:0]  head[46];
		logic [15:0] lens[3];
		logic [31:0] magic;
		logic [7:0]  b;
		int          head_len, len_at, stream_len, bad_at, i;
		head_len = loc ? 30 : 46;
		len_at   = loc ? 26 : 28;
		magic    = loc ? 32'h04034B50 : 32'h02014B50;
		bad_at   = 99;
		for (i = 0; i < 3; i++) begin
			if (shape == SHAPE_CUT)
				lens[i] = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
			else if (shape == SHAPE_BARE || $urandom_range(0, 2) == 0)
				lens[i] = 16'd0;
			else
				lens[i] = 16'($urandom_range(1, 5));
		end
		if (loc)
			lens[2] = 16'd0;
		for (i = 0; i < head_len; i++) begin
			if (i < 4)
				head[i] = magic[8*i +: 8];
			else if (flavor == 0)
				head[i] = 8'h00;
			else if (flavor == 1)
				head[i] = 8'hFF;
			else
				head[i] = pick_byte();
		end
		for (i = 0; i < (loc ? 2 : 3); i++) begin
			head[len_at + 2*i]     = lens[i][7:0];
			head[len_at + 2*i + 1] = lens[i][15:8];
		end
		if (shape == SHAPE_SPOILED) begin
			bad_at = $urandom_range(0, 3);
			head[bad_at] = head[bad_at] ^ 8'($urandom_range(1, 255));
		end
		if (shape == SHAPE_CUT)
			stream_len = $urandom_range(1, head_len + 6);
		else if (shape == SHAPE_SPOILED)
			stream_len = bad_at + 1 + $urandom_range(0, 3);
		else
			stream_len = head_len + int'(lens[0]) + int'(lens[1]) + int'(lens[2]);
		for (i = 0; i < stream_len; i++) begin
			if (i < head_len)
				b = head[i];
			else if (i - head_len < int'(lens[0]) && $urandom_range(0, 3) == 0)
				b = zdp_pkg::NUL_BYTE;
			else
				b = 8'($urandom);
			send_byte(b, i == 0, (i == 0) ? loc : 1'($urandom));
			if (i <= bad_at || shape != SHAPE_SPOILED)
				entry_bytes++;
		end
		entries_sent++;
	endtask

	// Input monitor feeds the predictor; output monitor checks each result transaction.
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.take_byte(in_ch.byte_value, in_ch.entry_start, in_ch.local_layout);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.match_result(out_ch.item_kind, out_ch.item_value, out_ch.entry_done);
	end

	// Receiver: random stalls, plus one long hold-off that fills the block.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = draw_wait();
				if (stall > 0) begin
					out_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
			$display("[zip_directory_entry_parser_top] ERROR");
			$finish;
		end
	end

	initial begin
		entry_shape_t shape;
		int           pick, flavor, i;
		bit           loc;
		sb = new();
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.byte_value   = 8'h00;
		in_ch.entry_start  = 1'b0;
		in_ch.local_layout = 1'b0;
		burst_mode         = 1'b0;
		hold_request       = 1'b0;
		entries_sent       = 0;
		entry_bytes        = 0;
		quiet_cycles       = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Bytes before any start mark are dropped.
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		// Signature broken on its first byte.
		send_byte(8'h00, 1'b1, 1'b0);
		// Local layout flag with a central signature: fails on the third byte.
		send_byte(8'h50, 1'b1, 1'b1);
		send_byte(8'h4B, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b1);
		// Central entry with a local final signature byte.
		send_byte(8'h50, 1'b1, 1'b0);
		send_byte(8'h4B, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h04, 1'b0, 1'b0);
		// A new start abandons a half-read signature, then the new one breaks on its second byte.
		send_byte(8'h50, 1'b1, 1'b1);
		send_byte(8'h4B, 1'b0, 1'b1);
		send_byte(8'h50, 1'b1, 1'b0);
		send_byte(8'hCB, 1'b0, 1'b0);
		// Bytes after a bad signature are skipped.
		send_byte(8'h50, 1'b0, 1'b0);

		// Entry stream: mostly well-formed entries with random fields, some broken.
		while (entry_bytes < RANDOM_ITEMS) begin
			burst_mode = ($urandom_range(0, 3) == 0);
			if (entries_sent == 0) begin
				loc = 1'b1; flavor = 0; shape = SHAPE_BARE;
			end else if (entries_sent == 1) begin
				loc = 1'b0; flavor = 1; shape = SHAPE_BARE;
			end else if (entries_sent == 2) begin
				loc = 1'b0; flavor = 2; shape = SHAPE_FULL;
				burst_mode   = 1'b1;
				hold_request = 1'b1;
			end else begin
				loc    = 1'($urandom);
				flavor = $urandom_range(0, 5);
				pick   = $urandom_range(0, 9);
				shape  = (pick == 0) ? SHAPE_SPOILED : (pick <= 2) ? SHAPE_CUT : SHAPE_FULL;
			end
			send_entry(loc, flavor, shape);
			// Trailing bytes without a start mark are ignored by a finished entry.
			if (shape != SHAPE_CUT && $urandom_range(0, 2) == 0)
				for (i = $urandom_range(1, 3); i > 0; i--)
					send_byte(8'($urandom), 1'b0, 1'($urandom));
		end
		in_ch.valid <= 1'b0;
		burst_mode = 1'b0;

		// Drain the outstanding fields, then allow a few cycles for stray results.
		for (i = 0; i < DRAIN_LIMIT && sb.fields_due.size() != 0; i++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.fields_due.size() != 0)
			sb.flag_mismatch($sformatf("%0d expected results never arrived",
				sb.fields_due.size()));

		$display("Run covered %0d entries (%0d entry bytes) after the signature cases.",
			entries_sent, entry_bytes);
		$display("Checked %0d results, %0d bad signatures, one %0d-cycle output hold.",
			sb.matched, sb.bad_sigs, HOLD_CYCLES);
		if (sb.errors == 0)
			$display("[zip_directory_entry_parser_top] OK");
		else
			$display("[zip_directory_entry_parser_top] ERROR");
		$finish;
	end

endmodule
